// ----- hdl/rts_pkg.sv -----
// rts_pkg: shared constants and types of the rgba8 tile swizzle block
// used by rts_ctrl, rts_out and rgba8_tile_swizzle; no dependencies
package rts_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int CFG_W = 9;
  localparam int WORD_W = 5;

  localparam logic [1:0] TILE_LAST = 2'd3;
  localparam logic [WORD_W-1:0] LAST_WORD = 5'd31;
  localparam logic [CFG_W-1:0] MAX_HEIGHT_TILES = 9'd256;

  // configuration register indexes
  localparam logic CFG_WIDTH_IDX = 1'b0;
  localparam logic CFG_HEIGHT_IDX = 1'b1;

  // tag that travels beside the store read data
  typedef struct packed {
    logic valid;
    logic upper_half;
    logic last_tile;
    logic last_image;
  } rd_tag_t;

endpackage

// ----- hdl/rts_store.sv -----
// rts_store: four-row pixel store, one write port and one read port
// read data registered; no package dependencies
module rts_store #(
  parameter int MAX_WIDTH = 1024,
  localparam int Depth = 4 * MAX_WIDTH,
  localparam int AW = $clog2(Depth)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [0:Depth-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/rts_ctrl.sv -----
// rts_ctrl: configuration registers, raster counters and tile read sequencer
// depends on rts_pkg; drives the write and read ports of rts_store
module rts_ctrl
  import rts_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AW = $clog2(4 * MAX_WIDTH),
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WPW = CW + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  logic             out_take,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  output rd_tag_t          tag
);

  localparam logic [31:0] MaxWTiles = 32'(MAX_WIDTH / 4);

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'b01,
    ST_EMIT   = 2'b10
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    width_in_tiles;
  logic [CFG_W-1:0]    height_in_tiles;
  logic [CW-1:0]       col;
  logic [1:0]          row;
  logic [7:0]          band;
  logic [WORD_W-1:0]   k;
  logic [CW-1:0]       base_col;
  logic                last_image_pend;

  logic [WPW-1:0]      wpix;
  logic [CFG_W-1:0]    h_eff;
  logic [CFG_W-1:0]    w_eff;
  logic [WPW-1:0]      col_inc;
  logic                row_end;
  logic                last_band;
  logic                tile_done;
  logic                pix_acc;
  logic                emitting;
  logic                issue;

  // effective sizes
  always_comb begin
    w_eff = (width_in_tiles == '0) ? CFG_W'(1) : width_in_tiles;
    if (32'(w_eff) > MaxWTiles) begin
      wpix = WPW'(MaxWTiles * 4);
    end else begin
      wpix = WPW'({w_eff, 2'b00});
    end
    if (height_in_tiles == '0) begin
      h_eff = CFG_W'(1);
    end else if (height_in_tiles > MAX_HEIGHT_TILES) begin
      h_eff = MAX_HEIGHT_TILES;
    end else begin
      h_eff = height_in_tiles;
    end
  end

  assign col_inc   = WPW'(col) + WPW'(1);
  assign row_end   = col_inc >= wpix;
  assign last_band = ({1'b0, band} + CFG_W'(1)) >= h_eff;
  assign tile_done = (row == TILE_LAST) && (col[1:0] == TILE_LAST);

  assign emitting    = (state == ST_EMIT);
  assign pixel_stall = rst || emitting;
  assign pix_acc     = pixel_valid && !pixel_stall;
  assign issue       = emitting && (!tag.valid || out_take);

  assign wr_en   = pix_acc;
  assign wr_addr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
  assign rd_en   = issue;
  assign rd_addr = AW'(k[3:2]) * AW'(MAX_WIDTH) + AW'(base_col | CW'(k[1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_tiles  <= CFG_W'(1);
      height_in_tiles <= CFG_W'(1);
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_WIDTH_IDX:  width_in_tiles <= cfg_data;
        CFG_HEIGHT_IDX: height_in_tiles <= cfg_data;
        default:        width_in_tiles <= cfg_data;
      endcase
    end
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      band <= '0;
    end else if (pix_acc) begin
      if (row_end) begin
        col <= '0;
        if (row == TILE_LAST) begin
          row  <= '0;
          band <= last_band ? 8'd0 : band + 8'd1;
        end else begin
          row <= row + 2'd1;
        end
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

  // tile read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
      k     <= '0;
    end else begin
      unique case (state)
        ST_ACCEPT: begin
          if (pix_acc && tile_done) begin
            state <= ST_EMIT;
            k     <= '0;
          end
        end
        ST_EMIT: begin
          if (issue) begin
            k <= k + WORD_W'(1);
            if (k == LAST_WORD) begin
              state <= ST_ACCEPT;
            end
          end
        end
        default: state <= ST_ACCEPT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc && tile_done) begin
      base_col        <= col & ~CW'(TILE_LAST);
      last_image_pend <= row_end && last_band;
    end
  end

  // tag of the word in the store read register
  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (issue) begin
      tag.valid <= 1'b1;
    end else if (out_take) begin
      tag.valid <= 1'b0;
    end
    if (issue) begin
      tag.upper_half <= k[4];
      tag.last_tile  <= (k == LAST_WORD);
      tag.last_image <= (k == LAST_WORD) && last_image_pend;
    end
  end

  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    pix_acc && tile_done |=> emitting && k == '0)
    else $error("tile emission did not start at word zero");

  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(emitting) |-> $past(issue) && $past(k) == LAST_WORD)
    else $error("tile emission ended before the last word");

  a_image_tag: assert property (@(posedge clk) disable iff (rst)
    tag.valid && tag.last_image |-> tag.last_tile)
    else $error("end of image tagged away from end of tile");

  a_counters_hold: assert property (@(posedge clk) disable iff (rst)
    !pix_acc |=> $stable(col) && $stable(row) && $stable(band))
    else $error("raster counters moved without an item");

endmodule

// ----- hdl/rts_out.sv -----
// rts_out: output register with byte selection of the swizzled word
// depends on rts_pkg; fed by rts_store read data and the rts_ctrl tag
module rts_out
  import rts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rd_tag_t     tag,
  input  logic [31:0] rd_data,
  output logic        take,
  output logic        word_valid,
  input  logic        word_stall,
  output logic [7:0]  first_byte,
  output logic [7:0]  second_byte,
  output logic        last_of_tile,
  output logic        last_of_image
);

  assign take = !word_valid || !word_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (take) begin
      word_valid <= tag.valid;
    end
  end

  // alpha and red first, green and blue second
  always_ff @(posedge clk) begin
    if (take && tag.valid) begin
      first_byte    <= tag.upper_half ? rd_data[15:8] : rd_data[31:24];
      second_byte   <= tag.upper_half ? rd_data[23:16] : rd_data[7:0];
      last_of_tile  <= tag.last_tile;
      last_of_image <= tag.last_image;
    end
  end

endmodule

// ----- hdl/rgba8_tile_swizzle.sv -----
// rgba8_tile_swizzle: top level of the rgba8 4x4 tile swizzler
// depends on rts_pkg, rts_store, rts_ctrl and rts_out
//
// Pixels enter in raster order on the pixel channel (red, green, blue,
// alpha) and are written into a four-row store. The pixel that completes a
// 4x4 tile starts a burst of 32 words on the word channel: 16 alpha/red
// pairs then 16 green/blue pairs, row by row inside the tile. last_of_tile
// marks word 31, last_of_image marks word 31 of the final tile.
// Image size is set through cfg_en/cfg_index/cfg_data in whole tiles:
// index 0 is width, index 1 is height; write only while idle.
// A pixel that does not complete a tile is taken without a stall. After a
// tile-completing pixel the sequencer enters its emit state; each word
// passes the store read register and then the output register. The
// burst reads the store once per word, so pixel_stall stays high until
// the last read is issued; the single store read port sets this stall.
// A word stall holds the output register and halts the store reads; the
// pixel channel stays stalled until all 32 reads are issued.
// Reset clears the counters and sets both sizes to one tile; the store is
// not cleared, so no clearing pass is needed.
module rgba8_tile_swizzle
  import rts_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  input  logic [7:0]       alpha,
  output logic             word_valid,
  input  logic             word_stall,
  output logic [7:0]       first_byte,
  output logic [7:0]       second_byte,
  output logic             last_of_tile,
  output logic             last_of_image
);

  localparam int AW = $clog2(4 * MAX_WIDTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          take;
  rd_tag_t       tag;

  rts_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .out_take   (take),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .tag        (tag)
  );

  rts_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data({alpha, blue, green, red}),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  rts_out u_out (
    .clk          (clk),
    .rst          (rst),
    .tag          (tag),
    .rd_data      (rd_data),
    .take         (take),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .first_byte   (first_byte),
    .second_byte  (second_byte),
    .last_of_tile (last_of_tile),
    .last_of_image(last_of_image)
  );

endmodule
